@@ design/c128sd_pkg.sv @@
// ----------------------------------------------------------------------------
// Code 128 symbol decoder package
// Shared types, the symbol width table and the character mapping.
// ----------------------------------------------------------------------------
package c128sd_pkg;

  localparam int unsigned WidthBitsDefault = 12;
  localparam int unsigned NumSymbols       = 106;
  localparam int unsigned QueueDepth       = 2;
  localparam int unsigned ModBits          = 3;

  localparam logic [7:0] CodeNone   = 8'hFF;
  localparam logic [7:0] CodeStartA = 8'hF5;
  localparam logic [6:0] FirstStart = 7'd103;
  localparam logic [6:0] FirstSpec  = 7'd96;
  localparam logic [6:0] FirstSpecC = 7'd100;
  localparam logic [6:0] FirstLowA  = 7'd64;

  typedef enum logic [1:0] {
    CMD_SET_A = 2'd0,
    CMD_SET_B = 2'd1,
    CMD_SET_C = 2'd2,
    CMD_START = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                         cmd;
    logic                         ok;
    logic [3:0][ModBits-1:0]      mods;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam logic [23:0] SymWidths [NumSymbols] = '{
    24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322, 24'h131222,
    24'h122213, 24'h122312, 24'h132212, 24'h221213, 24'h221312, 24'h231212,
    24'h112232, 24'h122132, 24'h122231, 24'h113222, 24'h123122, 24'h123221,
    24'h223211, 24'h221132, 24'h221231, 24'h213212, 24'h223112, 24'h312131,
    24'h311222, 24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
    24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123, 24'h131321,
    24'h112313, 24'h132113, 24'h132311, 24'h211313, 24'h231113, 24'h231311,
    24'h112133, 24'h112331, 24'h132131, 24'h113123, 24'h113321, 24'h133121,
    24'h313121, 24'h211331, 24'h231131, 24'h213113, 24'h213311, 24'h213131,
    24'h311123, 24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
    24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422, 24'h121124,
    24'h121421, 24'h141122, 24'h141221, 24'h112214, 24'h112412, 24'h122114,
    24'h122411, 24'h142112, 24'h142211, 24'h241211, 24'h221114, 24'h413111,
    24'h241112, 24'h134111, 24'h111242, 24'h121142, 24'h121241, 24'h114212,
    24'h124112, 24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
    24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141, 24'h114113,
    24'h114311, 24'h411113, 24'h411311, 24'h113141, 24'h114131, 24'h311141,
    24'h411131, 24'h211412, 24'h211214, 24'h211232
  };

  localparam logic [7:0] SpecA [7] = '{8'hFC, 8'hFD, 8'hFA, 8'hF6, 8'hF7, 8'hFB, 8'hFE};
  localparam logic [7:0] SpecB [7] = '{8'hFC, 8'hFD, 8'hFA, 8'hF6, 8'hFB, 8'hF9, 8'hFE};
  localparam logic [7:0] SpecC [7] = '{8'h63, 8'h63, 8'h63, 8'h63, 8'hF7, 8'hF9, 8'hFE};

  // Edge-to-edge sums of one table row, in modules.
  function automatic logic [3:0][3:0] sym_pattern(int unsigned idx);
    logic [23:0]     row;
    logic [3:0][3:0] pat;
    row = SymWidths[idx];
    for (int k = 0; k < 4; k++) begin
      pat[k] = row[4*(5-k) +: 4] + row[4*(4-k) +: 4];
    end
    return pat;
  endfunction

  function automatic logic [7:0] char_of(logic [6:0] v, cmd_e cmd);
    logic [6:0] off;
    logic [7:0] res;
    off = v - FirstSpec;
    if (v >= FirstStart) begin
      res = CodeStartA - {1'b0, v - FirstStart};
    end else if (cmd == CMD_SET_C) begin
      res = (v < FirstSpecC) ? {1'b0, v} : SpecC[off[2:0]];
    end else if (v >= FirstSpec) begin
      res = (cmd == CMD_SET_A) ? SpecA[off[2:0]] : SpecB[off[2:0]];
    end else if (cmd == CMD_SET_A && v >= FirstLowA) begin
      res = {1'b0, v - FirstLowA};
    end else begin
      res = {1'b0, v} + 8'd32;
    end
    return res;
  endfunction

endpackage

@@ design/c128sd_front.sv @@
// ----------------------------------------------------------------------------
// Code 128 front end
// Accepts widths, forms the total and edge sums, rounds them to modules.
// ----------------------------------------------------------------------------
module c128sd_front #(
  parameter int unsigned WIDTH_BITS = c128sd_pkg::WidthBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [WIDTH_BITS-1:0]     width_one_i,
  input  logic [WIDTH_BITS-1:0]     width_two_i,
  input  logic [WIDTH_BITS-1:0]     width_three_i,
  input  logic [WIDTH_BITS-1:0]     width_four_i,
  input  logic [WIDTH_BITS-1:0]     width_five_i,
  input  logic [WIDTH_BITS-1:0]     width_six_i,
  input  logic [1:0]                command_i,
  input  c128sd_pkg::queue_status_t status_i,
  output logic                      busy_o,
  output logic                      push_o,
  output c128sd_pkg::item_t         item_o
);
  import c128sd_pkg::*;

  localparam int unsigned SumBits  = WIDTH_BITS + 3;
  localparam int unsigned EdgeBits = WIDTH_BITS + 1;
  localparam int unsigned CmpBits  = WIDTH_BITS + 7;

  logic                     valid_q, valid_d;
  logic [SumBits-1:0]       p_q, p_d;
  logic [3:0][EdgeBits-1:0] e_q, e_d;
  cmd_e                     cmd_q, cmd_d;
  logic                     accept, advance;

  assign busy_o  = valid_q && status_i.full;
  assign accept  = start_i && !busy_o;
  assign advance = !valid_q || !status_i.full;
  assign push_o  = valid_q && !status_i.full;

  always_comb begin
    valid_d = advance ? accept : valid_q;
    p_d = SumBits'(width_one_i) + SumBits'(width_two_i) + SumBits'(width_three_i)
        + SumBits'(width_four_i) + SumBits'(width_five_i) + SumBits'(width_six_i);
    e_d[0] = EdgeBits'(width_one_i) + EdgeBits'(width_two_i);
    e_d[1] = EdgeBits'(width_two_i) + EdgeBits'(width_three_i);
    e_d[2] = EdgeBits'(width_three_i) + EdgeBits'(width_four_i);
    e_d[3] = EdgeBits'(width_four_i) + EdgeBits'(width_five_i);
    cmd_d  = cmd_e'(command_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q   <= p_d;
      e_q   <= e_d;
      cmd_q <= cmd_d;
    end
  end

  // A sum rounds to k modules when (2k-1)*p <= 22*e < (2k+1)*p, k = 2..7.
  always_comb begin
    logic [CmpBits-1:0] e22;
    logic [CmpBits-1:0] pw;
    logic [ModBits-1:0] n;
    logic               ok;
    ok = 1'b1;
    pw = CmpBits'(p_q);
    item_o.cmd  = cmd_q;
    item_o.mods = '0;
    for (int k = 0; k < 4; k++) begin
      e22 = (CmpBits'(e_q[k]) << 4) + (CmpBits'(e_q[k]) << 2) + (CmpBits'(e_q[k]) << 1);
      n = '0;
      for (int j = 3; j <= 13; j += 2) begin
        if (pw * CmpBits'(j) <= e22) begin
          n = n + ModBits'(1);
        end
      end
      if (n == '0 || !(e22 < pw * CmpBits'(15))) begin
        ok = 1'b0;
      end
      item_o.mods[k] = n + ModBits'(1);
    end
    item_o.ok = ok;
  end

endmodule

@@ design/c128sd_queue.sv @@
// ----------------------------------------------------------------------------
// Code 128 item queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module c128sd_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  c128sd_pkg::item_t         item_i,
  input  logic                      pop_i,
  output c128sd_pkg::item_t         head_o,
  output c128sd_pkg::queue_status_t status_o
);
  import c128sd_pkg::*;

  localparam int unsigned PtrBits = $clog2(QueueDepth);
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  item_t              mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign status_o.full  = (cnt_q == CntBits'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

@@ design/c128sd_back.sv @@
// ----------------------------------------------------------------------------
// Code 128 back end
// Matches module counts against the symbol table and registers the result.
// ----------------------------------------------------------------------------
module c128sd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  c128sd_pkg::queue_status_t status_i,
  input  c128sd_pkg::item_t         head_i,
  output logic                      pop_o,
  output logic                      done_o,
  output logic                      found_o,
  output logic [6:0]                symbol_value_o,
  output logic [7:0]                decoded_code_o
);
  import c128sd_pkg::*;

  logic                  done_q, done_d;
  logic                  found_q, found_d;
  logic [6:0]            value_q, value_d;
  logic [7:0]            code_q, code_d;
  logic [NumSymbols-1:0] hit;

  assign pop_o = !status_i.empty;

  always_comb begin
    logic [3:0][3:0] pat;
    for (int i = 0; i < NumSymbols; i++) begin
      pat = sym_pattern(i);
      hit[i] = head_i.ok;
      for (int k = 0; k < 4; k++) begin
        if ({1'b0, head_i.mods[k]} != pat[k]) begin
          hit[i] = 1'b0;
        end
      end
      if (head_i.cmd == CMD_START && 7'(i) < FirstStart) begin
        hit[i] = 1'b0;
      end
    end
  end

  always_comb begin
    done_d  = pop_o;
    found_d = 1'b0;
    value_d = '0;
    for (int i = NumSymbols - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found_d = 1'b1;
        value_d = 7'(i);
      end
    end
    code_d = found_d ? char_of(value_d, head_i.cmd) : CodeNone;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    value_q <= value_d;
    code_q  <= code_d;
  end

  assign done_o         = done_q;
  assign found_o        = found_q;
  assign symbol_value_o = value_q;
  assign decoded_code_o = code_q;

endmodule

@@ design/code128_symbol_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// Code 128 symbol decoder unit
// Flow: front end register, then queue entry, then back end result register raising done.
// Throughput: one symbol per cycle; busy stays low since the back end drains
// the two-entry queue every cycle and the receiver cannot stall.
// Reset: asynchronous, active low; clears the valid flags and queue pointers.
// ----------------------------------------------------------------------------
module code128_symbol_decoder_unit #(
  parameter int unsigned WIDTH_BITS = c128sd_pkg::WidthBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [WIDTH_BITS-1:0] width_one_i,
  input  logic [WIDTH_BITS-1:0] width_two_i,
  input  logic [WIDTH_BITS-1:0] width_three_i,
  input  logic [WIDTH_BITS-1:0] width_four_i,
  input  logic [WIDTH_BITS-1:0] width_five_i,
  input  logic [WIDTH_BITS-1:0] width_six_i,
  input  logic [1:0]            command_i,
  output logic                  done_o,
  output logic                  found_o,
  output logic [6:0]            symbol_value_o,
  output logic [7:0]            decoded_code_o
);
  import c128sd_pkg::*;

  queue_status_t status;
  item_t         item, head;
  logic          push, pop;

  c128sd_front #(
    .WIDTH_BITS(WIDTH_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .width_one_i  (width_one_i),
    .width_two_i  (width_two_i),
    .width_three_i(width_three_i),
    .width_four_i (width_four_i),
    .width_five_i (width_five_i),
    .width_six_i  (width_six_i),
    .command_i    (command_i),
    .status_i     (status),
    .busy_o       (busy_o),
    .push_o       (push),
    .item_o       (item)
  );

  c128sd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .pop_i   (pop),
    .head_o  (head),
    .status_o(status)
  );

  c128sd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .status_i      (status),
    .head_i        (head),
    .pop_o         (pop),
    .done_o        (done_o),
    .found_o       (found_o),
    .symbol_value_o(symbol_value_o),
    .decoded_code_o(decoded_code_o)
  );

`ifndef SYNTHESIS
  a_done_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(pop))
    else $error("Result strobe without a queue pop.");

  a_miss_defaults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (symbol_value_o == 7'd0 && decoded_code_o == CodeNone))
    else $error("Missed symbol returned nonzero fields.");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (symbol_value_o < 7'(NumSymbols)))
    else $error("Matched value outside the symbol table.");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("Front end stalled although the back end drains every cycle.");
`endif

endmodule

@@ bench/code128_symbol_decoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Code 128 symbol decoder unit testbench
// Sends measured bar and space widths with a code-set command, predicts the
// matched symbol value and character for each accepted word, and checks every
// done strobe against the oldest prediction. It runs directed cases for
// degenerate widths, rounding boundaries, code sets and start search, then
// random symbols with jitter and random noise.
// ----------------------------------------------------------------------------
module code128_symbol_decoder_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import c128sd_pkg::*;

  localparam int WB = WidthBitsDefault;
  localparam int MaxWidth = (1 << WB) - 1;
  localparam int StallLimit = 1000;

  localparam logic [0:105][23:0] ELEMENT_ROWS = {
    24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322, 24'h131222,
    24'h122213, 24'h122312, 24'h132212, 24'h221213, 24'h221312, 24'h231212,
    24'h112232, 24'h122132, 24'h122231, 24'h113222, 24'h123122, 24'h123221,
    24'h223211, 24'h221132, 24'h221231, 24'h213212, 24'h223112, 24'h312131,
    24'h311222, 24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
    24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123, 24'h131321,
    24'h112313, 24'h132113, 24'h132311, 24'h211313, 24'h231113, 24'h231311,
    24'h112133, 24'h112331, 24'h132131, 24'h113123, 24'h113321, 24'h133121,
    24'h313121, 24'h211331, 24'h231131, 24'h213113, 24'h213311, 24'h213131,
    24'h311123, 24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
    24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422, 24'h121124,
    24'h121421, 24'h141122, 24'h141221, 24'h112214, 24'h112412, 24'h122114,
    24'h122411, 24'h142112, 24'h142211, 24'h241211, 24'h221114, 24'h413111,
    24'h241112, 24'h134111, 24'h111242, 24'h121142, 24'h121241, 24'h114212,
    24'h124112, 24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
    24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141, 24'h114113,
    24'h114311, 24'h411113, 24'h411311, 24'h113141, 24'h114131, 24'h311141,
    24'h411131, 24'h211412, 24'h211214, 24'h211232
  };

  localparam logic [0:6][7:0] SPECIAL_A = {
    8'hFC, 8'hFD, 8'hFA, 8'hF6, 8'hF7, 8'hFB, 8'hFE
  };
  localparam logic [0:6][7:0] SPECIAL_B = {
    8'hFC, 8'hFD, 8'hFA, 8'hF6, 8'hFB, 8'hF9, 8'hFE
  };
  localparam logic [0:6][7:0] SPECIAL_C = {
    8'h63, 8'h63, 8'h63, 8'h63, 8'hF7, 8'hF9, 8'hFE
  };

  typedef logic [5:0][WB-1:0] widths_t;

  typedef struct packed {
    logic       found;
    logic [6:0] value;
    logic [7:0] code;
  } symbol_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start_i = 1'b0;
  logic          busy_o;
  logic [WB-1:0] width_one_i = '0;
  logic [WB-1:0] width_two_i = '0;
  logic [WB-1:0] width_three_i = '0;
  logic [WB-1:0] width_four_i = '0;
  logic [WB-1:0] width_five_i = '0;
  logic [WB-1:0] width_six_i = '0;
  logic [1:0]    command_i = CMD_SET_A;
  logic          done_o;
  logic          found_o;
  logic [6:0]    symbol_value_o;
  logic [7:0]    decoded_code_o;

  symbol_result_t pending_symbols [$];
  int  error_count = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  symbols_found = 0;
  int  stall_cycles = 0;
  bit  idle_enabled = 1'b1;

  code128_symbol_decoder_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .width_one_i    (width_one_i),
    .width_two_i    (width_two_i),
    .width_three_i  (width_three_i),
    .width_four_i   (width_four_i),
    .width_five_i   (width_five_i),
    .width_six_i    (width_six_i),
    .command_i      (command_i),
    .done_o         (done_o),
    .found_o        (found_o),
    .symbol_value_o (symbol_value_o),
    .decoded_code_o (decoded_code_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int element_of(int v, int k);
    logic [23:0] row;
    row = ELEMENT_ROWS[v];
    return int'(row[4*(5-k) +: 4]);
  endfunction

  function automatic logic [7:0] character_for(int v, cmd_e cmd);
    logic [7:0] c;
    if (v >= 103) begin
      c = 8'hF5 - 8'(v - 103);
    end else if (cmd == CMD_SET_C) begin
      c = (v < 100) ? 8'(v) : SPECIAL_C[v-96];
    end else if (v >= 96) begin
      c = (cmd == CMD_SET_A) ? SPECIAL_A[v-96] : SPECIAL_B[v-96];
    end else if (cmd == CMD_SET_A && v >= 64) begin
      c = 8'(v - 64);
    end else begin
      c = 8'(v + 32);
    end
    return c;
  endfunction

  function automatic symbol_result_t decode_symbol(widths_t w, cmd_e cmd);
    symbol_result_t r;
    int total;
    int edge_sum;
    int mods [4];
    bit rounded;
    bit hit;
    total = 0;
    rounded = 1'b1;
    r.found = 1'b0;
    r.value = '0;
    r.code = 8'hFF;
    for (int k = 0; k < 6; k++) total += int'(w[k]);
    for (int k = 0; k < 4; k++) begin
      edge_sum = 22 * (int'(w[k]) + int'(w[k+1]));
      mods[k] = 0;
      for (int m = 2; m <= 7; m++) begin
        if ((2*m - 1) * total <= edge_sum && edge_sum < (2*m + 1) * total) mods[k] = m;
      end
      if (mods[k] == 0) rounded = 1'b0;
    end
    if (rounded) begin
      for (int v = (cmd == CMD_START) ? 103 : 0; v < 106; v++) begin
        hit = 1'b1;
        for (int k = 0; k < 4; k++) begin
          if (element_of(v, k) + element_of(v, k + 1) != mods[k]) hit = 1'b0;
        end
        if (hit && !r.found) begin
          r.found = 1'b1;
          r.value = 7'(v);
          r.code = character_for(v, cmd);
        end
      end
    end
    return r;
  endfunction

  function automatic widths_t shape_symbol(int v, int scale, int jitter);
    widths_t w;
    int x;
    for (int k = 0; k < 6; k++) begin
      x = element_of(v, k) * scale;
      if (jitter > 0) x = x + $urandom_range(0, 2 * jitter) - jitter;
      if (x < 0) x = 0;
      if (x > MaxWidth) x = MaxWidth;
      w[k] = WB'(x);
    end
    return w;
  endfunction

  task automatic send_symbol(widths_t w, cmd_e cmd);
    int gap;
    gap = 0;
    if (idle_enabled) begin
      while ($urandom_range(0, 99) < 11) gap++;
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    width_one_i   <= w[0];
    width_two_i   <= w[1];
    width_three_i <= w[2];
    width_four_i  <= w[3];
    width_five_i  <= w[4];
    width_six_i   <= w[5];
    command_i     <= cmd;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    pending_symbols.push_back(decode_symbol(w, cmd));
    words_sent++;
  endtask

  task automatic test_degenerate_widths();
    send_symbol('0, CMD_SET_A);
    send_symbol({6{WB'(MaxWidth)}}, CMD_SET_B);
    send_symbol({WB'(0), WB'(0), WB'(0), WB'(0), WB'(0), WB'(MaxWidth)}, CMD_SET_C);
    send_symbol({WB'(MaxWidth), WB'(0), WB'(0), WB'(0), WB'(0), WB'(0)}, CMD_START);
    // Sums exactly on the 1.5, 3.5 and 5.5 module boundaries, then just below.
    send_symbol({WB'(4), WB'(4), WB'(6), WB'(5), WB'(2), WB'(1)}, CMD_SET_B);
    send_symbol({WB'(5), WB'(4), WB'(6), WB'(5), WB'(2), WB'(1)}, CMD_SET_B);
    send_symbol(shape_symbol(0, 4, 1), CMD_SET_A);
  endtask

  task automatic test_code_sets();
    cmd_e cmd;
    for (int c = 0; c < 3; c++) begin
      cmd = cmd_e'(c);
      send_symbol(shape_symbol(0, 1, 0), cmd);
      send_symbol(shape_symbol(100, 7, 0), cmd);
    end
    send_symbol(shape_symbol(82, 3, 0), CMD_SET_A);
    send_symbol(shape_symbol(64, 2, 0), CMD_SET_A);
    send_symbol(shape_symbol(95, 5, 0), CMD_SET_A);
    send_symbol(shape_symbol(63, 9, 0), CMD_SET_B);
    send_symbol(shape_symbol(96, 11, 0), CMD_SET_A);
    send_symbol(shape_symbol(101, 13, 0), CMD_SET_B);
    send_symbol(shape_symbol(102, 1023, 0), CMD_SET_C);
  endtask

  task automatic test_start_search();
    send_symbol(shape_symbol(103, 2, 0), CMD_START);
    send_symbol(shape_symbol(104, 6, 0), CMD_START);
    send_symbol(shape_symbol(105, 17, 0), CMD_START);
    send_symbol(shape_symbol(0, 3, 0), CMD_START);
    send_symbol(shape_symbol(103, 4, 0), CMD_SET_B);
  endtask

  task automatic test_random_symbols(int count);
    widths_t w;
    cmd_e cmd;
    int roll;
    int v;
    int scale;
    for (int n = 0; n < count; n++) begin
      idle_enabled = !(n >= 200 && n < 300);
      roll = $urandom_range(0, 99);
      cmd = cmd_e'($urandom_range(0, 3));
      if (roll < 75) begin
        if (cmd == CMD_START && $urandom_range(0, 1) == 1) v = $urandom_range(103, 105);
        else v = $urandom_range(0, 105);
        if ($urandom_range(0, 9) == 0) scale = $urandom_range(41, 1023);
        else scale = $urandom_range(1, 40);
        w = shape_symbol(v, scale, $urandom_range(0, scale / 2));
      end else if (roll < 90) begin
        for (int k = 0; k < 6; k++) w[k] = WB'($urandom_range(0, MaxWidth));
      end else begin
        for (int k = 0; k < 6; k++) w[k] = WB'($urandom_range(0, 15));
      end
      send_symbol(w, cmd);
    end
    idle_enabled = 1'b1;
  endtask

  always @(posedge clk_i) begin
    symbol_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_symbols.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual found %0b value %0d code %02h",
                 $time, found_o, symbol_value_o, decoded_code_o);
        error_count++;
      end else begin
        exp_r = pending_symbols.pop_front();
        words_checked++;
        if (found_o) symbols_found++;
        if (found_o !== exp_r.found) begin
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $time, exp_r.found, found_o);
          error_count++;
        end
        if (symbol_value_o !== exp_r.value) begin
          $display("%0t: symbol_value mismatch, expected %0d, actual %0d",
                   $time, exp_r.value, symbol_value_o);
          error_count++;
        end
        if (decoded_code_o !== exp_r.code) begin
          $display("%0t: decoded_code mismatch, expected %02h, actual %02h",
                   $time, exp_r.code, decoded_code_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: watchdog expired with %0d words outstanding",
               $time, pending_symbols.size());
      $display("code128_symbol_decoder_unit test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_degenerate_widths();
    test_code_sets();
    test_start_search();
    test_random_symbols(450);
    start_i <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d words over all four commands, checked %0d results, %0d matched.",
             words_sent, words_checked, symbols_found);
    $display("Covered degenerate and boundary widths, every code set and start search.");
    if (error_count == 0) begin
      $display("code128_symbol_decoder_unit test passed");
    end else begin
      $display("code128_symbol_decoder_unit test failed");
    end
    $finish;
  end

endmodule

@@ code128_symbol_decoder_unit.f @@
design/c128sd_pkg.sv
design/c128sd_front.sv
design/c128sd_queue.sv
design/c128sd_back.sv
design/code128_symbol_decoder_unit.sv
bench/code128_symbol_decoder_unit_tb.sv
